// ----- hdl/rbm_pkg.sv -----
// ----------------------------------------------------------------------------
// rbm_pkg
// Shared types and constants for the RGBA blend mode unit: channel width,
// blend mode codes, payload structs and lane control.
// ----------------------------------------------------------------------------
package rbm_pkg;

    localparam int CH_BITS   = 8;
    localparam int PROD_BITS = 2 * CH_BITS;
    localparam int SUM_BITS  = 2 * CH_BITS + 1;
    localparam int EST_BITS  = SUM_BITS - CH_BITS;
    localparam int NUM_LANES = 4;
    localparam int MODE_BITS = 4;

    typedef logic [CH_BITS-1:0]   channel_t;
    typedef logic [MODE_BITS-1:0] mode_t;

    localparam channel_t CH_MAX  = channel_t'((1 << CH_BITS) - 1);
    localparam channel_t CH_HALF = channel_t'(((1 << CH_BITS) - 2) / 2);
    localparam channel_t CH_MID  = channel_t'((1 << CH_BITS) / 2);

    localparam mode_t MODE_MULTIPLY   = 4'd0;
    localparam mode_t MODE_ADD        = 4'd1;
    localparam mode_t MODE_SUBTRACT   = 4'd2;
    localparam mode_t MODE_DIFFERENCE = 4'd3;
    localparam mode_t MODE_SCREEN     = 4'd4;
    localparam mode_t MODE_OVERLAY    = 4'd5;
    localparam mode_t MODE_LIGHTEN    = 4'd6;
    localparam mode_t MODE_DARKEN     = 4'd7;
    localparam mode_t MODE_COLOR_ONLY = 4'd8;

    localparam int LANE_RED   = 0;
    localparam int LANE_GREEN = 1;
    localparam int LANE_BLUE  = 2;
    localparam int LANE_ALPHA = 3;

    typedef struct packed {
        channel_t a_red;
        channel_t a_green;
        channel_t a_blue;
        channel_t a_alpha;
        channel_t b_red;
        channel_t b_green;
        channel_t b_blue;
        channel_t b_alpha;
    } pixel_pair_t;

    typedef struct packed {
        channel_t out_red;
        channel_t out_green;
        channel_t out_blue;
        channel_t out_alpha;
    } pixel_t;

    // Per-lane control carried from the product stage to the divide stage
    typedef struct packed {
        logic use_div;   // result comes from the normalized product
        logic dbl;       // overlay: product counts twice
        logic cmpl;      // result is M minus the quotient
    } lane_ctl_t;

endpackage

// ----- hdl/rbm_lane.sv -----
// ----------------------------------------------------------------------------
// rbm_lane
// One channel of the blend: stage one picks operands and multiplies,
// stage two divides by the channel maximum with rounding and selects.
// ----------------------------------------------------------------------------
module rbm_lane (
    input  logic           clk,
    input  rbm_pkg::mode_t mode,
    input  rbm_pkg::channel_t a,
    input  rbm_pkg::channel_t b,
    output rbm_pkg::channel_t res
);
    import rbm_pkg::*;

    channel_t                a_inv;
    channel_t                b_inv;
    channel_t                op_x;
    channel_t                op_y;
    logic [CH_BITS:0]        ab_sum;
    channel_t                simple_next;
    lane_ctl_t               ctl_next;
    logic                    use_inv;

    logic [PROD_BITS-1:0]    prod_reg;
    channel_t                simple_reg;
    lane_ctl_t               ctl_reg;

    logic [SUM_BITS-1:0]     num;
    logic [SUM_BITS-1:0]     est_sum;
    logic [EST_BITS-1:0]     est;
    logic [SUM_BITS-1:0]     est_times_max;
    logic [EST_BITS-1:0]     rem;
    logic [EST_BITS-1:0]     quot;
    channel_t                q;

    assign a_inv  = CH_MAX - a;
    assign b_inv  = CH_MAX - b;
    assign ab_sum = {1'b0, a} + {1'b0, b};

    always_comb
    begin
        simple_next = CH_MAX;
        ctl_next    = '0;
        use_inv     = 1'b0;
        case (mode)
            MODE_MULTIPLY:
            begin
                ctl_next.use_div = 1'b1;
            end
            MODE_ADD:
            begin
                simple_next = ab_sum[CH_BITS] ? CH_MAX : ab_sum[CH_BITS-1:0];
            end
            MODE_SUBTRACT:
            begin
                simple_next = (a > b) ? channel_t'(a - b) : '0;
            end
            MODE_DIFFERENCE:
            begin
                simple_next = (a > b) ? channel_t'(a - b) : channel_t'(b - a);
            end
            MODE_SCREEN:
            begin
                ctl_next.use_div = 1'b1;
                ctl_next.cmpl    = 1'b1;
                use_inv          = 1'b1;
            end
            MODE_OVERLAY:
            begin
                ctl_next.use_div = 1'b1;
                ctl_next.dbl     = 1'b1;
                ctl_next.cmpl    = (a >= CH_MID);
                use_inv          = (a >= CH_MID);
            end
            MODE_LIGHTEN:
            begin
                simple_next = (a > b) ? a : b;
            end
            MODE_DARKEN:
            begin
                simple_next = (a < b) ? a : b;
            end
            MODE_COLOR_ONLY:
            begin
                simple_next = b;
            end
            default:
            begin
                simple_next = CH_MAX;
            end
        endcase
    end

    assign op_x = use_inv ? a_inv : a;
    assign op_y = use_inv ? b_inv : b;

    always_ff @(posedge clk)
    begin
        prod_reg   <= PROD_BITS'(op_x) * PROD_BITS'(op_y);
        simple_reg <= simple_next;
        ctl_reg    <= ctl_next;
    end

    // Divide by M = 2^N - 1: the estimate is exact or one short, fix by one compare
    assign num = (ctl_reg.dbl ? {prod_reg, 1'b0} : {1'b0, prod_reg})
                 + SUM_BITS'(CH_HALF);
    assign est_sum       = num + (num >> CH_BITS);
    assign est           = est_sum[SUM_BITS-1:CH_BITS];
    assign est_times_max = (SUM_BITS'(est) << CH_BITS) - SUM_BITS'(est);
    assign rem           = EST_BITS'(num - est_times_max);
    assign quot          = est + EST_BITS'(rem >= EST_BITS'(CH_MAX));
    assign q             = quot[CH_BITS-1:0];

    assign res = ctl_reg.use_div ? (ctl_reg.cmpl ? channel_t'(CH_MAX - q) : q) : simple_reg;

endmodule

// ----- hdl/rbm_merge.sv -----
// ----------------------------------------------------------------------------
// rbm_merge
// Output stage: gathers the four lane results into one pixel beat and
// raises the strobe for one cycle.
// ----------------------------------------------------------------------------
module rbm_merge (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              valid,
    input  rbm_pkg::channel_t lane_res [rbm_pkg::NUM_LANES],
    output rbm_pkg::pixel_t   result,
    output logic              done
);
    import rbm_pkg::*;

    pixel_t result_reg;
    logic   done_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (valid)
        begin
            result_reg.out_red   <= lane_res[LANE_RED];
            result_reg.out_green <= lane_res[LANE_GREEN];
            result_reg.out_blue  <= lane_res[LANE_BLUE];
            result_reg.out_alpha <= lane_res[LANE_ALPHA];
        end
    end

    assign result = result_reg;
    assign done   = done_reg;

endmodule

// ----- hdl/rgba_blend_mode_unit.sv -----
// ----------------------------------------------------------------------------
// rgba_blend_mode_unit
// Blends two RGBA pixels under a configured mode; four channel lanes in
// parallel, alpha as the normalized product of both alphas (white in undefined modes).
// ----------------------------------------------------------------------------
//  channel   signals                         beat taken when
//  input     start, busy, pixels             start && !busy
//  result    done, result                    done (one cycle, no stall)
//  config    cfg_valid, cfg_ready, cfg_data  cfg_valid && cfg_ready
//
//  One pixel pair per cycle; the result passes the stage one and merge registers.
//  Stage one muxes operands and runs one 8x8 multiplier per lane; stage two
//  divides by the channel maximum and the merge register drives the outputs.
//  busy stays low and cfg_ready stays high. Reset clears the mode to
//  multiply and drops any beat in flight.
// ----------------------------------------------------------------------------
module rgba_blend_mode_unit (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    output logic                  busy,
    input  rbm_pkg::pixel_pair_t  pixels,
    output logic                  done,
    output rbm_pkg::pixel_t       result,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  rbm_pkg::mode_t        cfg_data
);
    import rbm_pkg::*;

    mode_t    mode_reg;
    mode_t    alpha_mode;
    logic     s1_valid_reg;
    channel_t a_ch     [NUM_LANES];
    channel_t b_ch     [NUM_LANES];
    mode_t    lane_mode[NUM_LANES];
    channel_t lane_res [NUM_LANES];

    assign busy      = 1'b0;
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg     <= MODE_MULTIPLY;
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                mode_reg <= cfg_data;
            end
            s1_valid_reg <= start && !busy;
        end
    end

    // Alpha multiplies in every defined mode; undefined modes give white
    assign alpha_mode = (mode_reg > MODE_COLOR_ONLY) ? mode_reg : MODE_MULTIPLY;

    assign a_ch[LANE_RED]   = pixels.a_red;
    assign a_ch[LANE_GREEN] = pixels.a_green;
    assign a_ch[LANE_BLUE]  = pixels.a_blue;
    assign a_ch[LANE_ALPHA] = pixels.a_alpha;
    assign b_ch[LANE_RED]   = pixels.b_red;
    assign b_ch[LANE_GREEN] = pixels.b_green;
    assign b_ch[LANE_BLUE]  = pixels.b_blue;
    assign b_ch[LANE_ALPHA] = pixels.b_alpha;

    assign lane_mode[LANE_RED]   = mode_reg;
    assign lane_mode[LANE_GREEN] = mode_reg;
    assign lane_mode[LANE_BLUE]  = mode_reg;
    assign lane_mode[LANE_ALPHA] = alpha_mode;

    for (genvar i = 0; i < NUM_LANES; i++)
    begin : g_lane
        rbm_lane u_lane (
            .clk  (clk),
            .mode (lane_mode[i]),
            .a    (a_ch[i]),
            .b    (b_ch[i]),
            .res  (lane_res[i])
        );
    end

    rbm_merge u_merge (
        .clk      (clk),
        .rst_n    (rst_n),
        .valid    (s1_valid_reg),
        .lane_res (lane_res),
        .result   (result),
        .done     (done)
    );

endmodule

// ----- hdl/rbm_checker.sv -----
// ----------------------------------------------------------------------------
// rbm_checker
// Port-level checks for the RGBA blend mode unit: latency, strobe origin
// and alpha behavior; bound to the top level.
// ----------------------------------------------------------------------------
module rbm_checker (
    input logic                 clk,
    input logic                 rst_n,
    input logic                 start,
    input logic                 busy,
    input rbm_pkg::pixel_pair_t pixels,
    input logic                 done,
    input rbm_pkg::pixel_t      result
);
    import rbm_pkg::*;

    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |-> ##2 done)
        else $error("accepted beat did not produce a result two cycles later");

    a_no_orphan: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start && !busy, 2))
        else $error("result strobe without an accepted beat");

    a_zero_alpha: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && (pixels.a_alpha == '0 || pixels.b_alpha == '0))
        |-> ##2 (result.out_alpha == '0 || result.out_alpha == CH_MAX))
        else $error("zero alpha input gave a nonzero, non-white alpha");

    a_full_alpha: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && pixels.a_alpha == CH_MAX && pixels.b_alpha == CH_MAX)
        |-> ##2 (result.out_alpha == CH_MAX))
        else $error("opaque inputs gave a non-opaque result");

endmodule

bind rgba_blend_mode_unit rbm_checker u_rbm_checker (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (start),
    .busy   (busy),
    .pixels (pixels),
    .done   (done),
    .result (result)
);

// ----- dv/rgba_blend_mode_unit_tb.sv -----
// ----------------------------------------------------------------------------
// rgba_blend_mode_unit_tb
// Self-checking bench for the RGBA blend mode unit. A queue of planned steps
// (pixel pairs, mode writes, drain points) feeds a clocked driver; a clocked
// monitor predicts each accepted pair under the current mode and checks
// every done beat in order against it. Directed corner pairs come first for
// each mode, undefined modes included, then random phases under several modes.
// ----------------------------------------------------------------------------
module rgba_blend_mode_unit_tb;

    timeunit 1ns;
    timeprecision 1ps;

    import rbm_pkg::*;

    localparam mode_t MODE_UNDEF_LO = 4'd9;
    localparam mode_t MODE_UNDEF_HI = 4'd15;

    localparam int SETTLE_CYCLES   = 4;
    localparam int TAIL_CYCLES     = 8;
    localparam int CYCLE_LIMIT     = 200000;
    localparam int GAP_PCT         = 32;
    localparam int RAND_PHASES     = 12;
    localparam int PHASE_PAIRS     = 100;
    localparam int QUIET_PHASE     = 4;
    localparam int DRAIN_PHASE     = 7;

    typedef enum logic [1:0] {
        STEP_PIXEL,
        STEP_MODE,
        STEP_DRAIN
    } step_kind_t;

    typedef struct {
        step_kind_t  kind;
        pixel_pair_t pair;
        mode_t       mode;
        bit          gaps;
    } plan_step_t;

    typedef struct {
        pixel_t      px;
        pixel_pair_t src;
        mode_t       mode;
    } blend_due_t;

    logic        clk       = 1'b0;
    logic        rst_n     = 1'b0;
    logic        start     = 1'b0;
    logic        busy;
    pixel_pair_t pixels    = '0;
    logic        done;
    pixel_t      result;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    mode_t       cfg_data  = MODE_MULTIPLY;

    plan_step_t  plan_q[$];
    blend_due_t  blend_due_q[$];

    mode_t       mode_shadow = MODE_MULTIPLY;
    int          beats_sent  = 0;
    int          results_got = 0;
    int          quiet_cnt   = 0;
    int          error_cnt   = 0;
    int          cycle_cnt   = 0;

    plan_step_t  next_step;
    logic        pix_go;
    logic        cfg_go;

    string       lane_name[4] = '{"red", "green", "blue", "alpha"};

    rgba_blend_mode_unit DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .pixels    (pixels),
        .done      (done),
        .result    (result),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        forever #6 clk = ~clk;
    end

    // --------------------------------------------------------------- predictor

    function automatic int norm_product(int x, int y);
        return (x * y + int'(CH_HALF)) / int'(CH_MAX);
    endfunction

    function automatic channel_t blend_lane(mode_t mode, int a, int b);
        int m;
        int r;
        m = int'(CH_MAX);
        case (mode)
            MODE_MULTIPLY:   r = norm_product(a, b);
            MODE_ADD:        r = (a + b > m) ? m : a + b;
            MODE_SUBTRACT:   r = (a > b) ? a - b : 0;
            MODE_DIFFERENCE: r = (a > b) ? a - b : b - a;
            MODE_SCREEN:     r = m - norm_product(m - a, m - b);
            MODE_OVERLAY:
            begin
                if (a < int'(CH_MID))
                    r = (2 * a * b + int'(CH_HALF)) / m;
                else
                    r = m - (2 * (m - a) * (m - b) + int'(CH_HALF)) / m;
            end
            MODE_LIGHTEN:    r = (a > b) ? a : b;
            MODE_DARKEN:     r = (a < b) ? a : b;
            MODE_COLOR_ONLY: r = b;
            default:         r = m;
        endcase
        return channel_t'(r);
    endfunction

    function automatic pixel_t blend_pixel(mode_t mode, pixel_pair_t p);
        pixel_t q;
        q.out_red   = blend_lane(mode, int'(p.a_red), int'(p.b_red));
        q.out_green = blend_lane(mode, int'(p.a_green), int'(p.b_green));
        q.out_blue  = blend_lane(mode, int'(p.a_blue), int'(p.b_blue));
        // undefined modes give white, alpha included
        if (mode > MODE_COLOR_ONLY)
            q.out_alpha = CH_MAX;
        else
            q.out_alpha = channel_t'(norm_product(int'(p.a_alpha), int'(p.b_alpha)));
        return q;
    endfunction

    task automatic flag_mismatch(string msg);
        $display("[%0t] MISMATCH %s", $realtime, msg);
        error_cnt++;
    endtask

    // ---------------------------------------------------------------- planning

    function automatic pixel_pair_t make_pair(int ar, int ag, int ab, int aa,
                                              int br, int bg, int bb, int ba);
        pixel_pair_t p;
        p.a_red   = channel_t'(ar);
        p.a_green = channel_t'(ag);
        p.a_blue  = channel_t'(ab);
        p.a_alpha = channel_t'(aa);
        p.b_red   = channel_t'(br);
        p.b_green = channel_t'(bg);
        p.b_blue  = channel_t'(bb);
        p.b_alpha = channel_t'(ba);
        return p;
    endfunction

    // lean on the extremes and the overlay threshold
    function automatic channel_t pick_channel();
        case ($urandom_range(9))
            0:       return '0;
            1:       return CH_MAX;
            2:       return CH_MID - channel_t'($urandom_range(1));
            default: return channel_t'($urandom_range(255));
        endcase
    endfunction

    function automatic pixel_pair_t random_pair();
        pixel_pair_t p;
        p.a_red   = pick_channel();
        p.a_green = pick_channel();
        p.a_blue  = pick_channel();
        p.a_alpha = pick_channel();
        p.b_red   = pick_channel();
        p.b_green = pick_channel();
        p.b_blue  = pick_channel();
        p.b_alpha = pick_channel();
        return p;
    endfunction

    task automatic plan_pixel(pixel_pair_t p, bit gaps);
        plan_step_t s;
        s.kind = STEP_PIXEL;
        s.pair = p;
        s.mode = MODE_MULTIPLY;
        s.gaps = gaps;
        plan_q.push_back(s);
    endtask

    task automatic plan_mode(mode_t m);
        plan_step_t s;
        s.kind = STEP_MODE;
        s.pair = '0;
        s.mode = m;
        s.gaps = 1'b1;
        plan_q.push_back(s);
    endtask

    task automatic plan_drain();
        plan_step_t s;
        s.kind = STEP_DRAIN;
        s.pair = '0;
        s.mode = MODE_MULTIPLY;
        s.gaps = 1'b0;
        plan_q.push_back(s);
    endtask

    task automatic plan_directed();
        // reset mode is multiply
        plan_pixel(make_pair(255, 255, 255, 255, 255, 255, 255, 255), 1'b1);
        plan_pixel(make_pair(0, 0, 0, 0, 0, 0, 0, 0), 1'b1);
        plan_pixel(make_pair(255, 0, 128, 255, 0, 255, 127, 128), 1'b1);
        plan_mode(MODE_ADD);
        plan_pixel(make_pair(200, 10, 255, 255, 100, 20, 255, 255), 1'b1);
        plan_mode(MODE_SUBTRACT);
        plan_pixel(make_pair(100, 200, 0, 128, 200, 100, 255, 128), 1'b1);
        plan_mode(MODE_DIFFERENCE);
        plan_pixel(make_pair(100, 200, 0, 1, 200, 100, 255, 254), 1'b1);
        plan_mode(MODE_SCREEN);
        plan_pixel(make_pair(0, 255, 128, 64, 0, 0, 128, 200), 1'b1);
        plan_mode(MODE_OVERLAY);
        plan_pixel(make_pair(127, 128, 0, 255, 200, 200, 255, 0), 1'b1);
        plan_pixel(make_pair(255, 127, 128, 90, 255, 255, 0, 90), 1'b1);
        plan_mode(MODE_LIGHTEN);
        plan_pixel(make_pair(10, 200, 77, 255, 20, 100, 77, 3), 1'b1);
        plan_mode(MODE_DARKEN);
        plan_pixel(make_pair(10, 200, 77, 255, 20, 100, 77, 3), 1'b1);
        plan_mode(MODE_COLOR_ONLY);
        plan_pixel(make_pair(11, 22, 33, 200, 44, 55, 66, 100), 1'b1);
        plan_mode(MODE_UNDEF_LO);
        plan_pixel(make_pair(0, 0, 0, 0, 0, 0, 0, 0), 1'b1);
        plan_mode(MODE_UNDEF_HI);
        plan_pixel(make_pair(1, 2, 3, 4, 5, 6, 7, 8), 1'b1);
    endtask

    task automatic plan_random();
        mode_t m;
        for (int ph = 0; ph < RAND_PHASES; ph++)
        begin
            // every defined mode once, then random codes including undefined
            if (ph <= int'(MODE_COLOR_ONLY))
                m = mode_t'(ph);
            else
                m = mode_t'($urandom_range(15));
            plan_mode(m);
            for (int n = 0; n < PHASE_PAIRS; n++)
            begin
                if (ph == DRAIN_PHASE && n == PHASE_PAIRS / 2)
                    plan_drain();
                plan_pixel(random_pair(), ph != QUIET_PHASE);
            end
        end
    endtask

    // ------------------------------------------------------------------ driver

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start     <= 1'b0;
            pixels    <= '0;
            cfg_valid <= 1'b0;
            cfg_data  <= MODE_MULTIPLY;
            quiet_cnt = 0;
        end
        else
        begin
            pix_go = start && busy;
            cfg_go = cfg_valid && !cfg_ready;
            if (start && !busy)
                beats_sent++;
            if (beats_sent == results_got && !pix_go && !cfg_go)
                quiet_cnt++;
            else
                quiet_cnt = 0;

            if (!pix_go && !cfg_go && plan_q.size() != 0)
            begin
                next_step = plan_q[0];
                case (next_step.kind)
                    STEP_PIXEL:
                    begin
                        if (!(next_step.gaps && $urandom_range(99) < GAP_PCT))
                        begin
                            pixels <= next_step.pair;
                            pix_go = 1'b1;
                            void'(plan_q.pop_front());
                        end
                    end
                    STEP_MODE:
                    begin
                        // write the mode only with the pipe empty
                        if (quiet_cnt >= SETTLE_CYCLES && $urandom_range(99) >= GAP_PCT)
                        begin
                            cfg_data <= next_step.mode;
                            cfg_go = 1'b1;
                            void'(plan_q.pop_front());
                        end
                    end
                    default:
                    begin
                        if (quiet_cnt >= SETTLE_CYCLES)
                            void'(plan_q.pop_front());
                    end
                endcase
            end
            start     <= pix_go;
            cfg_valid <= cfg_go;
        end
    end

    // ----------------------------------------------------------------- monitor

    always @(posedge clk or negedge rst_n)
    begin
        blend_due_t due;
        blend_due_t got_due;
        if (!rst_n)
        begin
            mode_shadow = MODE_MULTIPLY;
            results_got <= 0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
                mode_shadow = cfg_data;
            if (start && !busy)
            begin
                due.px   = blend_pixel(mode_shadow, pixels);
                due.src  = pixels;
                due.mode = mode_shadow;
                blend_due_q.push_back(due);
            end
            if (done)
            begin
                results_got <= results_got + 1;
                if (blend_due_q.size() == 0)
                    flag_mismatch($sformatf("unexpected result %h", result));
                else
                begin
                    got_due = blend_due_q.pop_front();
                    for (int i = 0; i < NUM_LANES; i++)
                    begin
                        if (result[31 - 8 * i -: 8] !== got_due.px[31 - 8 * i -: 8])
                            flag_mismatch($sformatf("%s got %h want %h (mode %0d, pair %h)",
                                lane_name[i], result[31 - 8 * i -: 8],
                                got_due.px[31 - 8 * i -: 8], got_due.mode, got_due.src));
                    end
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_cnt++;
        if (cycle_cnt > CYCLE_LIMIT)
        begin
            $display("rgba_blend_mode_unit_tb: errors");
            $finish;
        end
    end

    // -------------------------------------------------------------------- main

    initial
    begin
        plan_directed();
        plan_random();

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        // hold until every planned step is taken and the pipe drains
        while (plan_q.size() != 0 || start || cfg_valid)
            @(posedge clk);
        while (beats_sent != results_got)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);

        if (blend_due_q.size() != 0)
            flag_mismatch($sformatf("%0d results never arrived", blend_due_q.size()));

        if (error_cnt == 0)
            $display("rgba_blend_mode_unit_tb: clean");
        else
            $display("rgba_blend_mode_unit_tb: errors");
        $finish;
    end

endmodule

// ----- files.f -----
hdl/rbm_pkg.sv
hdl/rbm_lane.sv
hdl/rbm_merge.sv
hdl/rgba_blend_mode_unit.sv
hdl/rbm_checker.sv
dv/rgba_blend_mode_unit_tb.sv
